// ===== rtl/core/mhd_conserved_to_primitive_macros.svh =====
// Assertion macros for the MHD conserved-to-primitive block.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef MHD_CONSERVED_TO_PRIMITIVE_MACROS_SVH
`define MHD_CONSERVED_TO_PRIMITIVE_MACROS_SVH

`define MHD_C2P_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mhd_c2p assertion failed");

`define MHD_C2P_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mhd_c2p forbidden condition seen");

`endif

// ===== rtl/core/mhd_c2p_pkg.sv =====
// Shared types and constants for the MHD conserved-to-primitive block.
// No dependencies.
package mhd_c2p_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAMMA_BITS = 18;
  localparam int CFG_BITS   = GAMMA_BITS;

  localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = GAMMA_BITS'(43691);

  localparam logic CFG_IDX_GAMMA    = 1'b0;
  localparam logic CFG_IDX_MAGNETIC = 1'b1;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] density;
    logic signed [WORD_BITS-1:0] momentum_x;
    logic signed [WORD_BITS-1:0] momentum_y;
    logic signed [WORD_BITS-1:0] momentum_z;
    logic signed [WORD_BITS-1:0] energy;
    logic signed [WORD_BITS-1:0] field_x;
    logic signed [WORD_BITS-1:0] field_y;
    logic signed [WORD_BITS-1:0] field_z;
    logic                        last_cell;
  } c2p_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] density_out;
    logic signed [WORD_BITS-1:0] velocity_x;
    logic signed [WORD_BITS-1:0] velocity_y;
    logic signed [WORD_BITS-1:0] velocity_z;
    logic        [WORD_BITS-2:0] pressure;
    logic signed [WORD_BITS-1:0] field_x_out;
    logic signed [WORD_BITS-1:0] field_y_out;
    logic signed [WORD_BITS-1:0] field_z_out;
    logic                        bad_density;
    logic                        last_out;
  } c2p_out_t;

endpackage

// ===== rtl/core/mhd_c2p_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Carries an opaque sideband word alongside; no package dependencies.
module mhd_c2p_div #(
  parameter int Lanes    = 4,
  parameter int NumBits  = 64,
  parameter int DenBits  = 33,
  parameter int SideBits = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [Lanes-1:0][NumBits-1:0]     num_i,
  input  logic [Lanes-1:0][DenBits-1:0]     den_i,
  input  logic [SideBits-1:0]               side_i,
  output logic                              valid_o,
  output logic [Lanes-1:0][NumBits-1:0]     quo_o,
  output logic [SideBits-1:0]               side_o
);

  logic                          vld  [0:NumBits];
  logic [Lanes-1:0][NumBits-1:0] numq [0:NumBits];
  logic [Lanes-1:0][DenBits-1:0] rem  [0:NumBits];
  logic [Lanes-1:0][DenBits-1:0] den  [0:NumBits];
  logic [SideBits-1:0]           side [0:NumBits];

  assign vld[0]  = valid_i;
  assign numq[0] = num_i;
  assign rem[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [Lanes-1:0][NumBits-1:0] numq_d, numq_q;
    logic [Lanes-1:0][DenBits-1:0] rem_d, rem_q, den_q;
    logic [SideBits-1:0]           side_q;
    logic                          vld_q;

    always_comb begin
      logic [DenBits:0]   shifted;
      logic [DenBits+1:0] trial;
      for (int l = 0; l < Lanes; l++) begin
        shifted   = {rem[s][l], numq[s][l][NumBits-1]};
        trial     = {1'b0, shifted} - {2'b00, den[s][l]};
        numq_d[l] = {numq[s][l][NumBits-2:0], ~trial[DenBits+1]};
        rem_d[l]  = trial[DenBits+1] ? shifted[DenBits-1:0] : trial[DenBits-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      numq_q <= numq_d;
      rem_q  <= rem_d;
      den_q  <= den[s];
      side_q <= side[s];
    end

    assign vld[s+1]  = vld_q;
    assign numq[s+1] = numq_q;
    assign rem[s+1]  = rem_q;
    assign den[s+1]  = den_q;
    assign side[s+1] = side_q;
  end

  assign valid_o = vld[NumBits];
  assign quo_o   = numq[NumBits];
  assign side_o  = side[NumBits];

endmodule

// ===== rtl/core/mhd_conserved_to_primitive.sv =====
// Top level: MHD conserved-to-primitive conversion, one cell per word.
// Depends on mhd_c2p_pkg and mhd_c2p_div.
//
//  port group          dir  handshake
//  start_i/in_word_i   in   taken when start_i and not busy_o
//  done_o/result_o     out  one-cycle strobe, no back-pressure
//  cfg_we_i/idx/data   in   write on any edge with cfg_we_i
//
// A word is taken every cycle; busy_o stays low.
// Words pass through the capture, squares and operand registers, the
// bit-per-stage divider, then the P1, P2 and P3 registers.
// Reset clears valid bits and config registers; results cannot be stalled.
module mhd_conserved_to_primitive
  import mhd_c2p_pkg::*;
#(
  parameter int FractionBits = FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  c2p_in_t             in_word_i,
  output logic                done_o,
  output c2p_out_t            result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int W       = WORD_BITS;
  localparam int NumBits = (2 * W > W + FractionBits) ? 2 * W : W + FractionBits;
  localparam int DenBits = W + 1;
  localparam int ProdBits = GAMMA_BITS + W - 1;

  localparam logic [W-1:0]       TopBit = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0]       PMax   = '1;

  typedef struct packed {
    logic [W-1:0]   density;
    logic [W-1:0]   field_x;
    logic [W-1:0]   field_y;
    logic [W-1:0]   field_z;
    logic [W-1:0]   energy;
    logic [2*W-1:0] magnetic;
    logic [2:0]     neg;
    logic           bad;
    logic           last;
  } side_t;

  logic [GAMMA_BITS-1:0] gamma_q;
  logic                  incl_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q    <= GAMMA_RESET;
      incl_mag_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_GAMMA:    gamma_q    <= cfg_data_i;
        CFG_IDX_MAGNETIC: incl_mag_q <= cfg_data_i[0];
        default:          gamma_q    <= gamma_q;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: capture
  logic    s1_vld_q;
  c2p_in_t s1_q;

  // stage 2: squares
  logic                    s2_vld_q;
  c2p_in_t                 s2_q;
  logic [5:0][2*W-1:0]     sq_d, sq_q;

  // stage 3: divider operands
  logic                          s3_vld_q;
  logic [3:0][NumBits-1:0]       num_d, num_q;
  logic [3:0][DenBits-1:0]       den_d, den_q;
  side_t                         side_d, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i & ~busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_comb begin
    logic signed [W-1:0]   src [6];
    logic signed [2*W-1:0] prod;
    src[0] = s1_q.momentum_x;
    src[1] = s1_q.momentum_y;
    src[2] = s1_q.momentum_z;
    src[3] = s1_q.field_x;
    src[4] = s1_q.field_y;
    src[5] = s1_q.field_z;
    for (int i = 0; i < 6; i++) begin
      prod    = src[i] * src[i];
      sq_d[i] = unsigned'(prod);
    end
  end

  always_comb begin
    logic [W-1:0]   m [3];
    logic [W-1:0]   amag;
    logic [2*W-1:0] bsum;
    m[0] = s2_q.momentum_x;
    m[1] = s2_q.momentum_y;
    m[2] = s2_q.momentum_z;
    for (int i = 0; i < 3; i++) begin
      amag       = m[i][W-1] ? W'(0) - m[i] : m[i];
      num_d[i]   = NumBits'({amag, {FractionBits{1'b0}}});
      den_d[i]   = {1'b0, s2_q.density};
      side_d.neg[i] = m[i][W-1];
    end
    num_d[3] = NumBits'(sq_q[0] + sq_q[1] + sq_q[2]);
    den_d[3] = {s2_q.density, 1'b0};
    bsum     = sq_q[3] + sq_q[4] + sq_q[5];
    side_d.magnetic = incl_mag_q ? (bsum >> (FractionBits + 1)) : '0;
    side_d.density  = s2_q.density;
    side_d.field_x  = s2_q.field_x;
    side_d.field_y  = s2_q.field_y;
    side_d.field_z  = s2_q.field_z;
    side_d.energy   = s2_q.energy;
    side_d.bad      = s2_q.density[W-1] | (s2_q.density == '0);
    side_d.last     = s2_q.last_cell;
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= in_word_i;
    s2_q   <= s1_q;
    sq_q   <= sq_d;
    num_q  <= num_d;
    den_q  <= den_d;
    side_q <= side_d;
  end

  logic                    dv_vld;
  logic [3:0][NumBits-1:0] quo;
  logic [$bits(side_t)-1:0] dv_side_raw;
  side_t                   dv_side;

  mhd_c2p_div #(
    .Lanes   (4),
    .NumBits (NumBits),
    .DenBits (DenBits),
    .SideBits($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .side_o  (dv_side_raw)
  );

  assign dv_side = side_t'(dv_side_raw);

  // P1: loss, inner energy, velocity saturation
  logic              p1_vld_q, p2_vld_q, done_q;
  logic [2:0][W-1:0] vel_d, vel_q, vel2_q;
  logic [W-2:0]      inner_d, inner_q;
  logic              ok_d, ok_q, ok2_q;
  side_t             p1_side_q, p2_side_q;
  logic [ProdBits-1:0] pw_q;
  c2p_out_t          out_q;

  always_comb begin
    logic [NumBits:0] loss;
    logic [NumBits-1:0] lim;
    logic [W-1:0]       vmag;
    loss = {1'b0, quo[3]} + (NumBits+1)'(dv_side.magnetic);
    ok_d = ~dv_side.energy[W-1] & (dv_side.energy != '0)
         & (loss < (NumBits+1)'(dv_side.energy));
    inner_d = dv_side.energy[W-2:0] - loss[W-2:0];
    for (int i = 0; i < 3; i++) begin
      lim      = dv_side.neg[i] ? NumBits'(TopBit) : NumBits'(TopBit - W'(1));
      vmag     = (quo[i] > lim) ? lim[W-1:0] : quo[i][W-1:0];
      vel_d[i] = dv_side.neg[i] ? W'(0) - vmag : vmag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p1_vld_q <= dv_vld;
      p2_vld_q <= p1_vld_q;
      done_q   <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vel_q     <= vel_d;
    inner_q   <= inner_d;
    ok_q      <= ok_d;
    p1_side_q <= dv_side;
    vel2_q    <= vel_q;
    ok2_q     <= ok_q;
    p2_side_q <= p1_side_q;
    pw_q      <= ProdBits'(gamma_q) * ProdBits'(inner_q);
  end

  // P3: pressure scale, clamp, floor
  always_ff @(posedge clk_i) begin
    logic [ProdBits-1:0] ps;
    logic [W-2:0]        p;
    ps = pw_q >> FractionBits;
    if (ps > ProdBits'(PMax)) begin
      p = PMax;
    end else if (ps == '0) begin
      p = (W-1)'(1);
    end else begin
      p = ps[W-2:0];
    end
    if (p2_side_q.bad || !ok2_q) begin
      p = (W-1)'(1);
    end
    out_q.density_out <= p2_side_q.density;
    out_q.velocity_x  <= p2_side_q.bad ? '0 : vel2_q[0];
    out_q.velocity_y  <= p2_side_q.bad ? '0 : vel2_q[1];
    out_q.velocity_z  <= p2_side_q.bad ? '0 : vel2_q[2];
    out_q.pressure    <= p;
    out_q.field_x_out <= p2_side_q.field_x;
    out_q.field_y_out <= p2_side_q.field_y;
    out_q.field_z_out <= p2_side_q.field_z;
    out_q.bad_density <= p2_side_q.bad;
    out_q.last_out    <= p2_side_q.last;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

// ===== rtl/core/mhd_c2p_checker.sv =====
// Port-level checks for the MHD conserved-to-primitive block, and its bind.
// Depends on mhd_c2p_pkg and mhd_conserved_to_primitive_macros.svh.
`include "mhd_conserved_to_primitive_macros.svh"

module mhd_c2p_checker
  import mhd_c2p_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     done_o,
  input c2p_out_t result_o
);

  logic vel_zero;
  logic p_one;
  logic dens_pos;

  assign vel_zero = (result_o.velocity_x == '0) && (result_o.velocity_y == '0)
                 && (result_o.velocity_z == '0);
  assign p_one    = (result_o.pressure == (WORD_BITS-1)'(1));
  assign dens_pos = !result_o.density_out[WORD_BITS-1] && (result_o.density_out != '0);

  `MHD_C2P_ASSERT(a_pressure_floor, done_o |-> result_o.pressure != '0)
  `MHD_C2P_ASSERT(a_bad_word, (done_o && result_o.bad_density) |-> (vel_zero && p_one))
  `MHD_C2P_NEVER(a_good_density, done_o && !result_o.bad_density && !dens_pos)
  `MHD_C2P_NEVER(a_never_busy, start_i && busy_o)

endmodule

bind mhd_conserved_to_primitive mhd_c2p_checker u_checker (.*);
